@@ design/irpk_pkg.sv @@
// ----------------------------------------------------------------------------
// irpk_pkg
// Shared constants, register indexes and the front-to-back command type.
// ----------------------------------------------------------------------------
package irpk_pkg;

	localparam int WORD_BITS  = 16;
	localparam int MAX_RUN    = 15;
	localparam int MAX_PERIOD = 64;

	localparam int RUN_W  = 4;
	localparam int PER_W  = 7;
	localparam int BV_W   = 5;
	localparam int POS_W  = $clog2(WORD_BITS);
	localparam int TAKE_W = $clog2(WORD_BITS + 1);
	localparam int CNT_W  = $clog2(MAX_RUN * MAX_PERIOD + 1);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_CARRIER_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODULATED      = 1'd1;

	localparam int QDEPTH = 2;

	typedef struct packed {
		logic             level;
		logic [CNT_W-1:0] len_a;
		logic [PER_W-1:0] len_b;
		logic [CNT_W-1:0] total;
		logic             flush;
	} cmd_t;

endpackage

@@ design/irpk_front.sv @@
// ----------------------------------------------------------------------------
// irpk_front
// Configuration registers; accepts run items and turns them into commands.
// ----------------------------------------------------------------------------
module irpk_front import irpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PER_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_pulse,
	input  logic [RUN_W-1:0]     in_run,
	input  logic                 in_flush,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 q_full
);

	logic [PER_W-1:0] period_q;
	logic             modulated_q;
	logic [PER_W-1:0] period;
	logic [RUN_W-1:0] run;
	logic [CNT_W-1:0] total;
	logic [PER_W-1:0] low_half;
	logic [PER_W-1:0] high_half;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q    <= PER_W'(16);
			modulated_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_CARRIER_PERIOD: period_q    <= cfg_data;
				REG_MODULATED:      modulated_q <= cfg_data[0];
			endcase
		end
	end

	always_comb begin
		if (period_q == '0)
			period = PER_W'(1);
		else if (period_q > PER_W'(MAX_PERIOD))
			period = PER_W'(MAX_PERIOD);
		else
			period = period_q;
		run       = (in_run > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : in_run;
		total     = CNT_W'(CNT_W'(run) * CNT_W'(period));
		low_half  = period >> 1;
		high_half = period - low_half;
	end

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		push_cmd.level = in_pulse;
		push_cmd.total = total;
		push_cmd.flush = in_flush;
		if (in_pulse && modulated_q) begin
			push_cmd.len_a = CNT_W'(high_half);
			push_cmd.len_b = low_half;
		end else begin
			push_cmd.len_a = total;
			push_cmd.len_b = '0;
		end
	end

endmodule

@@ design/irpk_queue.sv @@
// ----------------------------------------------------------------------------
// irpk_queue
// Short command FIFO between the front and the back.
// ----------------------------------------------------------------------------
module irpk_queue import irpk_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output cmd_t head,
	output logic empty,
	output logic full
);

	localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int CT_W  = $clog2(QDEPTH + 1);

	cmd_t             mem_q [QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CT_W-1:0]  count_q;

	assign empty = (count_q == '0);
	assign full  = (count_q == CT_W'(QDEPTH));
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ design/irpk_back.sv @@
// ----------------------------------------------------------------------------
// irpk_back
// Bit sequencer: packs phase chunks into words and holds the output register.
// ----------------------------------------------------------------------------
module irpk_back import irpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_empty,
	input  cmd_t                 head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [WORD_BITS-1:0] out_word,
	output logic [BV_W-1:0]      out_bits,
	output logic                 out_last
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN_A = 2'd1;
	localparam logic [1:0] ST_RUN_B = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0]           state_q;
	cmd_t                 cmd_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     rem_q;
	logic [WORD_BITS-1:0] partial_q;
	logic [POS_W-1:0]     pos_q;

	logic                 out_valid_q;
	logic [WORD_BITS-1:0] out_word_q;
	logic [BV_W-1:0]      out_bits_q;
	logic                 out_last_q;

	logic                 slot_free;
	logic                 running;
	logic                 level;
	logic [TAKE_W-1:0]    space;
	logic [TAKE_W-1:0]    take;
	logic [TAKE_W-1:0]    new_pos;
	logic                 word_full;
	logic [WORD_BITS:0]   ones_w;
	logic [WORD_BITS-1:0] fill_mask;
	logic [WORD_BITS-1:0] new_word;
	logic [CNT_W-1:0]     rem_next;
	logic [CNT_W-1:0]     cnt_next;
	logic                 emit;

	assign slot_free = !out_valid_q || out_ready;
	assign running   = (state_q == ST_RUN_A) || (state_q == ST_RUN_B);
	assign pop       = (state_q == ST_IDLE) && !q_empty;
	assign level     = (state_q == ST_RUN_A) ? cmd_q.level : 1'b0;

	always_comb begin
		space     = TAKE_W'(WORD_BITS) - TAKE_W'(pos_q);
		take      = (cnt_q < CNT_W'(space)) ? TAKE_W'(cnt_q) : space;
		new_pos   = TAKE_W'(pos_q) + take;
		word_full = (new_pos == TAKE_W'(WORD_BITS));
		ones_w    = ({{WORD_BITS{1'b0}}, 1'b1} << take) - {{WORD_BITS{1'b0}}, 1'b1};
		fill_mask = ones_w[WORD_BITS-1:0] << pos_q;
		new_word  = level ? (partial_q | fill_mask) : partial_q;
		rem_next  = rem_q - CNT_W'(take);
		cnt_next  = cnt_q - CNT_W'(take);
		emit      = slot_free && ((running && word_full) || (state_q == ST_FLUSH));
	end

	always_ff @(posedge clk) begin
		if (pop)
			cmd_q <= head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			rem_q       <= '0;
			partial_q   <= '0;
			pos_q       <= '0;
			out_valid_q <= 1'b0;
			out_word_q  <= '0;
			out_bits_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cnt_q <= head.len_a;
						rem_q <= head.total;
						if (head.total != '0)
							state_q <= ST_RUN_A;
						else if (head.flush && pos_q != '0)
							state_q <= ST_FLUSH;
					end
				end
				ST_RUN_A, ST_RUN_B: begin
					if (slot_free) begin
						rem_q <= rem_next;
						if (word_full) begin
							out_word_q  <= new_word;
							out_bits_q  <= BV_W'(WORD_BITS);
							out_last_q  <= (rem_next < CNT_W'(WORD_BITS)) &&
							               !(cmd_q.flush && rem_next != '0);
							partial_q   <= '0;
							pos_q       <= '0;
						end else begin
							partial_q <= new_word;
							pos_q     <= new_pos[POS_W-1:0];
						end
						if (rem_next == '0) begin
							state_q <= (cmd_q.flush && !word_full) ? ST_FLUSH : ST_IDLE;
						end else if (cnt_next != '0) begin
							cnt_q <= cnt_next;
						end else if (state_q == ST_RUN_A && cmd_q.len_b != '0) begin
							state_q <= ST_RUN_B;
							cnt_q   <= CNT_W'(cmd_q.len_b);
						end else begin
							state_q <= ST_RUN_A;
							cnt_q   <= cmd_q.len_a;
						end
					end
				end
				ST_FLUSH: begin
					if (slot_free) begin
						out_word_q  <= partial_q;
						out_bits_q  <= BV_W'(pos_q);
						out_last_q  <= 1'b1;
						partial_q   <= '0;
						pos_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_bits  = out_bits_q;
	assign out_last  = out_last_q;

	// short words only come from a flush, which always ends the transaction set
	a_partial_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_bits_q != BV_W'(WORD_BITS) |-> out_last_q)
		else $error("partial word without last");

	a_flush_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FLUSH |-> pos_q != '0)
		else $error("flush state with empty packer");

	a_run_counts: assert property (@(posedge clk) disable iff (!arst_n)
		running |-> rem_q != '0 && cnt_q != '0 && cnt_q <= rem_q)
		else $error("run counters inconsistent");

	a_upper_bits_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(partial_q >> pos_q) == '0)
		else $error("bits set above fill position");

	a_word_held: assert property (@(posedge clk) disable iff (!arst_n)
		running && !slot_free |=> $stable(rem_q) && $stable(pos_q))
		else $error("sequencer advanced while output blocked");

endmodule

@@ design/ir_pulse_train_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_train_bit_packer_top
// Infrared run codes expanded into a packed LSB-first stream of 16-bit words.
// ----------------------------------------------------------------------------
// Each input transaction is a pause or pulse run of carrier periods; the bits
// are packed earliest-first into 16-bit words, each word sent as it fills, and
// a flush sends the zero-padded partial word. The front takes one transaction
// per cycle, while the queue is not full, into a two-entry command queue; the
// back sequencer loads a command while idle, then packs it chunk by chunk, a
// chunk ending at a word boundary or at a carrier phase boundary, and sends a
// flushed partial word from its flush state. Output stalls hold the sequencer;
// configuration must be written only while idle, which the block itself leaves
// unchecked.
// ----------------------------------------------------------------------------
module ir_pulse_train_bit_packer_top import irpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PER_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [3:0] run_periods, [7:4] zero
	input  logic                 s_tuser,   // [0] is_pulse
	input  logic                 s_tlast,   // flush
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [23:0]          m_tdata,   // [15:0] word, [20:16] bits_valid, [23:21] zero
	output logic                 m_tlast    // last
);

	logic                 push;
	cmd_t                 push_cmd;
	logic                 pop;
	cmd_t                 head;
	logic                 q_empty;
	logic                 q_full;
	logic [WORD_BITS-1:0] out_word;
	logic [BV_W-1:0]      out_bits;

	irpk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_pulse  (s_tuser),
		.in_run    (s_tdata[RUN_W-1:0]),
		.in_flush  (s_tlast),
		.push      (push),
		.push_cmd  (push_cmd),
		.q_full    (q_full)
	);

	irpk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.empty    (q_empty),
		.full     (q_full)
	);

	irpk_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_word  (out_word),
		.out_bits  (out_bits),
		.out_last  (m_tlast)
	);

	assign m_tdata = {3'b000, out_bits, out_word};

endmodule

@@ sim/ir_pulse_train_bit_packer_checker.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_train_bit_packer_checker
// Watches the register, run and word channels and scores the packed words.
// ----------------------------------------------------------------------------
// Register writes update a local copy of the period and mode. Every accepted
// run transaction is expanded bit by bit into the words it must produce, which
// wait in order until the block sends them; each word transaction is then
// compared field by field with the oldest waiting word.
// ----------------------------------------------------------------------------
module ir_pulse_train_bit_packer_checker import irpk_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [PER_W-1:0]     cfg_data,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [7:0]           s_tdata,   // [3:0] run_periods, [7:4] zero
	input  logic                 s_tuser,   // [0] is_pulse
	input  logic                 s_tlast,   // flush
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [23:0]          m_tdata,   // [15:0] word, [20:16] bits_valid, [23:21] zero
	input  logic                 m_tlast,   // last
	output int                   mismatch_count,
	output int                   outstanding,
	output int                   words_checked
);

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [BV_W-1:0]      bits_valid;
		logic                 last;
	} packed_word_t;

	packed_word_t pending_words[$];
	packed_word_t fresh_words[$];

	logic [PER_W-1:0]     period_reg;
	logic                 modulated_reg;
	logic [WORD_BITS-1:0] acc_word;
	int                   acc_fill;

	task automatic pack_bits(input logic value, input int count);
		for (int i = 0; i < count; i++) begin
			if (value)
				acc_word[acc_fill] = 1'b1;
			acc_fill++;
			if (acc_fill == WORD_BITS) begin
				fresh_words.push_back('{acc_word, BV_W'(WORD_BITS), 1'b0});
				acc_word = '0;
				acc_fill = 0;
			end
		end
	endtask

	task automatic expand_run(input logic pulse, input logic [RUN_W-1:0] run, input logic flush);
		int period;
		int periods;
		int ones;
		period  = int'(period_reg);
		periods = int'(run);
		if (period < 1)
			period = 1;
		if (period > MAX_PERIOD)
			period = MAX_PERIOD;
		if (periods > MAX_RUN)
			periods = MAX_RUN;
		fresh_words.delete();
		if (!pulse) begin
			pack_bits(1'b0, periods * period);
		end else if (!modulated_reg) begin
			pack_bits(1'b1, periods * period);
		end else begin
			// odd period: the ones phase takes the extra bit
			ones = period - period / 2;
			for (int p = 0; p < periods; p++) begin
				pack_bits(1'b1, ones);
				pack_bits(1'b0, period / 2);
			end
		end
		if (flush && acc_fill > 0) begin
			fresh_words.push_back('{acc_word, BV_W'(acc_fill), 1'b0});
			acc_word = '0;
			acc_fill = 0;
		end
		if (fresh_words.size() > 0)
			fresh_words[fresh_words.size() - 1].last = 1'b1;
		foreach (fresh_words[i])
			pending_words.push_back(fresh_words[i]);
	endtask

	task automatic flag_mismatch(input string what, input packed_word_t want);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s: expected word %h bits %0d last %b, got word %h bits %0d last %b pad %b",
				$realtime, what, want.word, want.bits_valid, want.last,
				m_tdata[15:0], m_tdata[20:16], m_tlast, m_tdata[23:21]);
	endtask

	always @(posedge clk) begin
		packed_word_t want;
		if (!arst_n) begin
			period_reg     = PER_W'(16);
			modulated_reg  = 1'b0;
			acc_word       = '0;
			acc_fill       = 0;
			pending_words.delete();
			mismatch_count = 0;
			outstanding    = 0;
			words_checked  = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_CARRIER_PERIOD)
					period_reg = cfg_data;
				else if (cfg_index == REG_MODULATED)
					modulated_reg = cfg_data[0];
			end
			if (s_tvalid && s_tready)
				expand_run(s_tuser, s_tdata[RUN_W-1:0], s_tlast);
			if (m_tvalid && m_tready) begin
				words_checked++;
				if (pending_words.size() == 0) begin
					flag_mismatch("word with none expected", '0);
				end else begin
					want = pending_words.pop_front();
					if (m_tdata !== {3'b000, want.bits_valid, want.word} || m_tlast !== want.last)
						flag_mismatch("word mismatch", want);
				end
			end
			outstanding = pending_words.size();
		end
	end

endmodule

@@ sim/ir_pulse_train_bit_packer_top_test.sv @@
// ----------------------------------------------------------------------------
// ir_pulse_train_bit_packer_top_test
// Stimulus and verdict for the infrared pulse-train bit packer.
// ----------------------------------------------------------------------------
// Runs directed pause and pulse runs over the period and mode extremes, a
// long output stall that backs up the run queue, then random runs under
// several register settings with random gaps on both channels. Scoring is
// done by the checker instantiated beside the block.
// ----------------------------------------------------------------------------
module ir_pulse_train_bit_packer_top_test;
	import irpk_pkg::*;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PER_W-1:0]     cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;   // [3:0] run_periods, [7:4] zero
	logic                 s_tuser;   // [0] is_pulse
	logic                 s_tlast;   // flush
	logic                 m_tvalid;
	logic                 m_tready;
	logic [23:0]          m_tdata;   // [15:0] word, [20:16] bits_valid, [23:21] zero
	logic                 m_tlast;   // last

	int mismatch_count;
	int outstanding;
	int words_checked;
	int runs_sent = 0;
	int reg_writes = 0;
	int hold_requests = 0;
	bit no_idle = 1'b0;

	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES  = 400;

	ir_pulse_train_bit_packer_top u_dut (.*);

	ir_pulse_train_bit_packer_checker u_checker (.*);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		#4000000;
		$display("[ir_pulse_train_bit_packer_top] ERROR");
		$finish;
	end

	// word channel: random stall per word, plus long hold-offs on request
	initial begin
		int stall;
		int holds_served;
		m_tready = 1'b0;
		holds_served = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (hold_requests != holds_served) begin
				m_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				holds_served = hold_requests;
			end
			stall = no_idle ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_tready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready = 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	task automatic send_run(input logic pulse, input logic [RUN_W-1:0] run, input logic flush);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 11);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = pulse;
		s_tdata  = {4'b0000, run};
		s_tlast  = flush;
		do @(posedge clk); while (!s_tready);
		runs_sent++;
	endtask

	task automatic send_random_run();
		send_run(1'($urandom_range(0, 1)), RUN_W'($urandom_range(0, 15)),
			$urandom_range(0, 3) == 0);
	endtask

	// sender pauses until every word is back and the block has gone quiet
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PER_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
		reg_writes++;
	endtask

	task automatic set_mode(input logic [PER_W-1:0] period, input logic [PER_W-1:0] mode);
		drain();
		write_reg(REG_CARRIER_PERIOD, period);
		write_reg(REG_MODULATED, mode);
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_CARRIER_PERIOD;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		s_tlast   = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: period 16, solid pulses
		send_run(1'b0, 4'd15, 1'b0);
		send_run(1'b1, 4'd1, 1'b0);
		send_run(1'b1, 4'd0, 1'b1);   // flush on an empty packer
		// period 0 is treated as 1
		set_mode(7'd0, 7'd0);
		send_run(1'b1, 4'd3, 1'b0);
		send_run(1'b0, 4'd2, 1'b1);
		send_run(1'b1, 4'd0, 1'b0);
		// period above the maximum saturates; mode bit is bit 0 only
		set_mode(7'd127, 7'h7F);
		send_run(1'b1, 4'd15, 1'b1);
		send_run(1'b0, 4'd1, 1'b1);
		// odd period: ones phase takes the extra bit
		set_mode(7'd7, 7'd1);
		send_run(1'b1, 4'd5, 1'b0);
		send_run(1'b0, 4'd3, 1'b1);
		send_run(1'b1, 4'd15, 1'b1);
		set_mode(7'd1, 7'd1);
		send_run(1'b1, 4'd15, 1'b0);
		send_run(1'b0, 4'd4, 1'b1);
		set_mode(7'd64, 7'h40);
		send_run(1'b1, 4'd15, 1'b0);
		send_run(1'b1, 4'd8, 1'b1);
		set_mode(7'd2, 7'd1);
		send_run(1'b1, 4'd15, 1'b1);
		send_run(1'b0, 4'd0, 1'b1);

		// long output stall while runs keep coming
		set_mode(7'd13, 7'd1);
		hold_requests++;
		no_idle = 1'b1;
		repeat (8) send_random_run();
		no_idle = 1'b0;

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: set_mode(7'd63, 7'd0);
				1: set_mode(PER_W'($urandom_range(1, 64)), PER_W'($urandom_range(0, 127)));
				2: set_mode(PER_W'($urandom_range(0, 127)), PER_W'($urandom_range(0, 127)));
				3: set_mode(PER_W'($urandom_range(1, 9)), 7'd1);
				default: set_mode(7'd64, 7'd1);
			endcase
			no_idle = (phase == 2);
			repeat (18) send_random_run();
			no_idle = 1'b0;
		end

		drain();
		$display("Sent %0d runs over %0d register writes; checked %0d words.",
			runs_sent, reg_writes, words_checked);
		$display("Periods 0 to 127, solid and carrier pulses, flushes and a long output stall.");
		if (mismatch_count == 0 && outstanding == 0)
			$display("[ir_pulse_train_bit_packer_top] OK");
		else
			$display("[ir_pulse_train_bit_packer_top] ERROR");
		$finish;
	end

endmodule

@@ files.f @@
design/irpk_pkg.sv
design/irpk_front.sv
design/irpk_queue.sv
design/irpk_back.sv
design/ir_pulse_train_bit_packer_top.sv
sim/ir_pulse_train_bit_packer_checker.sv
sim/ir_pulse_train_bit_packer_top_test.sv
